>>> rtl/core/slcr_pkg.sv
// shared constants, codes and text tables of the serial line command responder
package slcr_pkg;

    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 2;
    localparam int LINE_DEPTH_DEF = 64;

    // reply kind codes
    localparam logic [KIND_W-1:0] KIND_PONG = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    // command prefixes and fixed replies, first character in the top byte
    localparam logic [8*4-1:0]  TXT_PING = "PING";
    localparam logic [8*5-1:0]  TXT_ECHO = "ECHO ";
    localparam logic [8*6-1:0]  TXT_PONG = "PONG\r\n";
    localparam logic [8*2-1:0]  TXT_TAIL = "\r\n";
    localparam logic [8*5-1:0]  TXT_ERR  = "ERR\r\n";
    localparam logic [8*18-1:0] TXT_LONG = {"ERR:CMD", "_TOO_LONG", "\r\n"};

    localparam int TXT_IDX_W = 5;

    // character of the ping command at a position
    function automatic logic [BYTE_W-1:0] ping_char(input logic [1:0] pos);
        logic [BYTE_W-1:0] c;
        c = TXT_PING[8*(3 - int'(pos)) +: 8];
        return c;
    endfunction

    // character of the echo prefix at a position below five
    function automatic logic [BYTE_W-1:0] echo_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        c = CHAR_NUL;
        if (pos < 3'd5) begin
            c = TXT_ECHO[8*(4 - int'(pos)) +: 8];
        end
        return c;
    endfunction

    // byte of a fixed reply text
    function automatic logic [BYTE_W-1:0] text_byte(input logic [KIND_W-1:0] kind,
                                                    input logic [TXT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        c = CHAR_NUL;
        case (kind)
            KIND_PONG: if (idx < 5'd6)  c = TXT_PONG[8*(5 - int'(idx)) +: 8];
            KIND_ECHO: if (idx < 5'd2)  c = TXT_TAIL[8*(1 - int'(idx)) +: 8];
            KIND_ERR:  if (idx < 5'd5)  c = TXT_ERR[8*(4 - int'(idx)) +: 8];
            default:   if (idx < 5'd18) c = TXT_LONG[8*(17 - int'(idx)) +: 8];
        endcase
        return c;
    endfunction

    // index of the final byte of a fixed reply text
    function automatic logic [TXT_IDX_W-1:0] text_last(input logic [KIND_W-1:0] kind);
        logic [TXT_IDX_W-1:0] n;
        case (kind)
            KIND_PONG: n = 5'd5;
            KIND_ECHO: n = 5'd1;
            KIND_ERR:  n = 5'd4;
            default:   n = 5'd17;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/slcr_in_if.sv
// received byte channel of the serial line command responder
interface slcr_in_if;
    logic                         valid;
    logic                         ready;
    logic [slcr_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/slcr_out_if.sv
// response byte channel of the serial line command responder
interface slcr_out_if;
    logic                         valid;
    logic                         ready;
    logic [slcr_pkg::BYTE_W-1:0]  out_byte;
    logic [slcr_pkg::KIND_W-1:0]  reply_kind;
    logic                         last;

    modport source (output valid, output out_byte, output reply_kind, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input reply_kind, input last,
                    output ready);
endinterface

>>> rtl/core/slcr_ram.sv
// generic single port write, single port read ram with registered read data
module slcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/serial_line_command_responder.sv
// top level of the serial line command responder
// a fixed reply reaches the output through the ST_TEXT state and then the output register;
//   an echo with content goes through ST_ECHO_RD (line store read), ST_ECHO_OUT and the output register
// throughput: one received word per cycle while no reply is pending; fixed reply text
//   one word per cycle while the receiver is ready, echoed words read one at a time from the line store
// the block takes no received word while a reply is being sent
// synchronous active low reset empties the line and drops any pending reply
module serial_line_command_responder #(
    parameter int LINE_DEPTH = slcr_pkg::LINE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    slcr_in_if.sink             i_in,
    slcr_out_if.source          o_out
);
    import slcr_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int IW = (AW > TXT_IDX_W) ? AW : TXT_IDX_W;
    localparam logic [AW-1:0] CAP = AW'(LINE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO_RD,
        ST_ECHO_OUT,
        ST_TEXT
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_len, n_len;
    logic [AW-1:0]       r_eff, n_eff;
    logic                r_zero, n_zero;
    logic                r_ping_ok, n_ping_ok;
    logic                r_echo_ok, n_echo_ok;
    logic [IW-1:0]       r_idx, n_idx;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;
    logic                r_out_last, n_out_last;

    logic                in_acc;
    logic                is_eol;
    logic                store_ok;
    logic                out_free;
    logic                first;
    logic                ping_match;
    logic                echo_match;
    logic                mem_we;
    logic                mem_re;
    logic [BYTE_W-1:0]   mem_rdata;
    logic [TXT_IDX_W-1:0] txt_idx;

    assign in_acc   = i_in.valid && (r_state == ST_IDLE);
    assign is_eol   = (i_in.in_byte == CHAR_CR) || (i_in.in_byte == CHAR_LF);
    assign store_ok = (r_len < CAP);
    assign out_free = !r_out_valid || o_out.ready;
    assign first    = (r_len == '0);
    assign txt_idx  = r_idx[TXT_IDX_W-1:0];

    // per position prefix compare of the incoming word
    assign ping_match = (r_len > AW'(3)) || (i_in.in_byte == ping_char(r_len[1:0]));
    assign echo_match = (r_len > AW'(4)) || (i_in.in_byte == echo_char(r_len[2:0]));

    // line store
    assign mem_we = in_acc && !is_eol && store_ok;
    assign mem_re = (r_state == ST_ECHO_RD);

    slcr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len),
        .i_wdata (i_in.in_byte),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // next state and reply sequencing
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_eff       = r_eff;
        n_zero      = r_zero;
        n_ping_ok   = r_ping_ok;
        n_echo_ok   = r_echo_ok;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_eol) begin
                        if (!first) begin
                            n_len  = '0;
                            n_zero = 1'b0;
                            n_idx  = '0;
                            if ((r_eff == AW'(4)) && r_ping_ok) begin
                                n_kind  = KIND_PONG;
                                n_state = ST_TEXT;
                            end else if ((r_eff >= AW'(5)) && r_echo_ok) begin
                                n_kind = KIND_ECHO;
                                if (r_eff == AW'(5)) begin
                                    n_state = ST_TEXT;
                                end else begin
                                    n_idx   = IW'(5);
                                    n_state = ST_ECHO_RD;
                                end
                            end else begin
                                n_kind  = KIND_ERR;
                                n_state = ST_TEXT;
                            end
                        end
                    end else if (store_ok) begin
                        n_len     = r_len + AW'(1);
                        n_ping_ok = (first || r_ping_ok) && ping_match;
                        n_echo_ok = (first || r_echo_ok) && echo_match;
                        if (first) begin
                            n_zero = (i_in.in_byte == CHAR_NUL);
                            n_eff  = (i_in.in_byte == CHAR_NUL) ? AW'(0) : AW'(1);
                        end else if (!r_zero) begin
                            if (i_in.in_byte == CHAR_NUL) begin
                                n_zero = 1'b1;
                            end else begin
                                n_eff = r_len + AW'(1);
                            end
                        end
                    end else begin
                        n_len   = '0;
                        n_zero  = 1'b0;
                        n_idx   = '0;
                        n_kind  = KIND_LONG;
                        n_state = ST_TEXT;
                    end
                end
            end
            ST_ECHO_RD: begin
                n_state = ST_ECHO_OUT;
            end
            ST_ECHO_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = mem_rdata;
                    n_out_kind  = KIND_ECHO;
                    n_out_last  = 1'b0;
                    if ((r_idx + IW'(1)) == IW'(r_eff)) begin
                        n_idx   = '0;
                        n_state = ST_TEXT;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_ECHO_RD;
                    end
                end
            end
            ST_TEXT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = text_byte(r_kind, txt_idx);
                    n_out_kind  = r_kind;
                    n_out_last  = (txt_idx == text_last(r_kind));
                    if (txt_idx == text_last(r_kind)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_eff       <= '0;
            r_zero      <= 1'b0;
            r_ping_ok   <= 1'b0;
            r_echo_ok   <= 1'b0;
            r_idx       <= '0;
            r_kind      <= KIND_PONG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_eff       <= n_eff;
            r_zero      <= n_zero;
            r_ping_ok   <= n_ping_ok;
            r_echo_ok   <= n_echo_ok;
            r_idx       <= n_idx;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
        r_out_byte <= n_out_byte;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.reply_kind = r_out_kind;
    assign o_out.last       = r_out_last;

    // line length never passes the store capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP)
        else $error("line length beyond capacity");

    // while idle, content length up to the first zero never passes the length of a non-empty line
    a_eff_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_eff <= r_len) || first)
        else $error("content length beyond line length");

    // echo reads stay inside the line content
    a_echo_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ECHO_RD) |-> (r_idx < IW'(r_eff)) && (r_idx >= IW'(5)))
        else $error("echo read outside line content");

    // a final word is followed by no reply word until a new line ends or overflows the store
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEXT && out_free && txt_idx == text_last(r_kind))
        |=> (r_state == ST_IDLE))
        else $error("reply did not finish on its final word");

endmodule

>>> sim/tb.sv
// self-checking testbench of the serial line command responder
`timescale 1ns / 1ps

module tb;
    import slcr_pkg::*;

    localparam int LINE_CAP    = LINE_DEPTH_DEF - 1;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] reply_kind;
        logic              last;
    } t_reply_word;

    logic i_clk;
    logic i_rst_n;

    slcr_in_if  line_in ();
    slcr_out_if reply_out ();

    serial_line_command_responder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (line_in),
        .o_out   (reply_out)
    );

    // stimulus and expectation stores
    logic [BYTE_W-1:0] tx_bytes [$];
    t_reply_word       expected_replies [$];

    // shadow copy of the line being collected
    logic [BYTE_W-1:0] line_buf [LINE_DEPTH_DEF];
    int                line_len;

    int words_in;
    int total_words;
    int hold_at;
    int hold_left;
    bit hold_done;
    int errors;
    int replies_checked;
    int kind_count [4];

    always #5 i_clk = ~i_clk;

    // idle share in percent for the current third of the run
    function automatic int idle_share(bit sender_side);
        int third;
        third = total_words / 3;
        if (words_in < third) begin
            return sender_side ? 17 : 70;
        end else if (words_in < 2 * third) begin
            return sender_side ? 70 : 17;
        end
        return 0;
    endfunction

    function automatic void push_word(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] kind,
                                      logic last);
        expected_replies.push_back('{b, kind, last});
    endfunction

    // body text followed by cr lf, last flag on the lf
    function automatic void reply_text(string body, logic [KIND_W-1:0] kind);
        for (int i = 0; i < body.len(); i++) begin
            push_word(body[i], kind, 1'b0);
        end
        push_word(CHAR_CR, kind, 1'b0);
        push_word(CHAR_LF, kind, 1'b1);
    endfunction

    // decode a finished line into its reply
    function automatic void answer_line();
        int    eff;
        bit    is_ping;
        bit    is_echo;
        string ping_txt;
        string echo_txt;
        ping_txt = "PING";
        echo_txt = "ECHO ";
        eff = 0;
        // a zero byte cuts the line short
        while (eff < line_len && line_buf[eff] != CHAR_NUL) begin
            eff++;
        end
        is_ping = (eff == 4);
        if (is_ping) begin
            for (int i = 0; i < 4; i++) begin
                if (line_buf[i] != ping_txt[i]) is_ping = 1'b0;
            end
        end
        is_echo = (eff >= 5);
        if (is_echo) begin
            for (int i = 0; i < 5; i++) begin
                if (line_buf[i] != echo_txt[i]) is_echo = 1'b0;
            end
        end
        if (is_ping) begin
            reply_text("PONG", KIND_PONG);
        end else if (is_echo) begin
            for (int i = 5; i < eff; i++) begin
                push_word(line_buf[i], KIND_ECHO, 1'b0);
            end
            reply_text("", KIND_ECHO);
        end else begin
            reply_text("ERR", KIND_ERR);
        end
    endfunction

    // track one accepted word and queue the reply it causes
    function automatic void respond_to_byte(logic [BYTE_W-1:0] b);
        string long_head;
        string long_tail;
        long_head = "ERR:CMD";
        long_tail = "_TOO_LONG";
        if (b == CHAR_CR || b == CHAR_LF) begin
            // blank lines are ignored
            if (line_len != 0) answer_line();
            line_len = 0;
        end else if (line_len < LINE_CAP) begin
            line_buf[line_len] = b;
            line_len++;
        end else begin
            // overflowing word is dropped along with the line
            line_len = 0;
            reply_text({long_head, long_tail}, KIND_LONG);
        end
    endfunction

    // stimulus helpers
    function automatic void send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            tx_bytes.push_back(s[i]);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] body_byte(int nul_pct);
        logic [BYTE_W-1:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == CHAR_CR || b == CHAR_LF);
        if ($urandom_range(99) < nul_pct) b = CHAR_NUL;
        return b;
    endfunction

    function automatic void send_body(int n, int nul_pct);
        for (int i = 0; i < n; i++) begin
            tx_bytes.push_back(body_byte(nul_pct));
        end
    endfunction

    function automatic void send_end();
        tx_bytes.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(3) == 0) tx_bytes.push_back(CHAR_LF);
    endfunction

    // store filled to the brim, then one word too many
    function automatic void send_overflow();
        send_body(LINE_CAP + 1, 3);
        if ($urandom_range(1)) send_text("PING");
        send_end();
    endfunction

    // longest echo the store can hold
    function automatic void send_full_echo();
        send_text("ECHO ");
        send_body(LINE_CAP - 5, 0);
        send_end();
    endfunction

    function automatic void send_random_line();
        int pick;
        int v;
        pick = $urandom_range(99);
        v    = $urandom_range(3);
        if (pick < 20) begin
            // ping and close misses
            case (v)
                0: send_text("PING");
                1: begin
                    send_text("PING");
                    tx_bytes.push_back(CHAR_NUL);
                    send_body($urandom_range(1, 3), 0);
                end
                2: begin
                    send_text("PIN");
                    send_body(1, 0);
                end
                default: begin
                    send_text("PING");
                    send_body(1, 10);
                end
            endcase
            send_end();
        end else if (pick < 50) begin
            send_text("ECHO ");
            send_body($urandom_range(0, 12), 5);
            send_end();
        end else if (pick < 65) begin
            send_body($urandom_range(1, 10), 5);
            send_end();
        end else if (pick < 73) begin
            case (v)
                0: send_text("ECHO");
                1: send_text("ECH0 x");
                2: send_text("ping");
                default: send_text("PINGG");
            endcase
            send_end();
        end else if (pick < 81) begin
            // blank lines and stray line ends
            send_end();
        end else if (pick < 89) begin
            // raw noise, line ends included
            for (int i = 0; i <= v; i++) begin
                tx_bytes.push_back(8'($urandom_range(255)));
            end
        end else if (pick < 94) begin
            send_full_echo();
        end else begin
            send_overflow();
        end
    endfunction

    // sender: offers the next word when the channel is free and the idle share of the current third allows
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_in.valid   <= 1'b0;
            line_in.in_byte <= '0;
            words_in        <= 0;
        end else begin
            if (line_in.valid && line_in.ready) begin
                respond_to_byte(line_in.in_byte);
                words_in <= words_in + 1;
            end
            if (!line_in.valid || line_in.ready) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= idle_share(1'b1)) begin
                    line_in.in_byte <= tx_bytes.pop_front();
                    line_in.valid   <= 1'b1;
                end else begin
                    line_in.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once the run has reached its no-idle third
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_in >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reply_out.ready <= 1'b0;
        end else begin
            reply_out.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_share(1'b0));
        end
    end

    // reply checker
    always @(posedge i_clk) begin
        t_reply_word want;
        if (i_rst_n && reply_out.valid && reply_out.ready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply word %h kind %0d last %0d",
                       reply_out.out_byte, reply_out.reply_kind, reply_out.last);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (reply_out.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, reply_out.out_byte);
                    errors++;
                end
                if (reply_out.reply_kind !== want.reply_kind) begin
                    $error("reply_kind: expected %0d, got %0d",
                           want.reply_kind, reply_out.reply_kind);
                    errors++;
                end
                if (reply_out.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, reply_out.last);
                    errors++;
                end
                replies_checked++;
                kind_count[want.reply_kind]++;
            end
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        line_in.valid   = 1'b0;
        line_in.in_byte = '0;
        reply_out.ready = 1'b0;
        line_len        = 0;
        errors          = 0;
        replies_checked = 0;
        total_words     = 1;
        hold_at         = 1;
        foreach (kind_count[k]) kind_count[k] = 0;

        // directed lines: blank, ping, bare echo, echo of an extreme word cut by a zero, unknown command
        tx_bytes.push_back(CHAR_CR);
        send_text("PING");
        tx_bytes.push_back(CHAR_CR);
        send_text("ECHO ");
        tx_bytes.push_back(CHAR_LF);
        send_text("ECHO ");
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(CHAR_NUL);
        send_text("Z");
        tx_bytes.push_back(CHAR_CR);
        send_text("?");
        tx_bytes.push_back(CHAR_LF);

        // random part, opening with a too-long line and a full-store echo
        send_overflow();
        send_full_echo();
        while (tx_bytes.size() < 370) begin
            send_random_line();
        end
        total_words = tx_bytes.size();
        hold_at     = 2 * (total_words / 3) + 10;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_in < total_words) @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d received words and %0d checked reply words",
                 total_words, replies_checked);
        $display("reply words by kind: pong %0d, echo %0d, error %0d, too long %0d",
                 kind_count[KIND_PONG], kind_count[KIND_ECHO], kind_count[KIND_ERR],
                 kind_count[KIND_LONG]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
